### design/spd_pkg.sv
package spd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SMSC = 2'd0,
        KIND_DEST = 2'd1,
        KIND_TEXT = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    // Header position, one-hot
    typedef enum logic [12:0] {
        PH_SMSC_LEN = 13'b0_0000_0000_0001,
        PH_SMSC_TOA = 13'b0_0000_0000_0010,
        PH_SMSC_DIG = 13'b0_0000_0000_0100,
        PH_FIRST    = 13'b0_0000_0000_1000,
        PH_MR       = 13'b0_0000_0001_0000,
        PH_DA_LEN   = 13'b0_0000_0010_0000,
        PH_DA_TOA   = 13'b0_0000_0100_0000,
        PH_DA_DIG   = 13'b0_0000_1000_0000,
        PH_PID      = 13'b0_0001_0000_0000,
        PH_DCS      = 13'b0_0010_0000_0000,
        PH_SCTS     = 13'b0_0100_0000_0000,
        PH_UDL      = 13'b0_1000_0000_0000,
        PH_UD       = 13'b1_0000_0000_0000
    } t_phase;

    // Message types from the first octet
    localparam logic [1:0] TYPE_DELIVER = 2'd0;
    localparam logic [1:0] TYPE_SUBMIT  = 2'd1;

    // DCS code for UCS-2 text
    localparam logic [7:0] DCS_UCS2 = 8'h08;

    // Semi-octet filler nibble
    localparam logic [3:0] FILLER_NIBBLE = 4'hF;

    // Timestamp length in octets
    localparam logic [7:0] SCTS_OCTETS = 8'd7;

    // Results one octet can cause
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic        last;
    } t_result;

endpackage

### design/spd_if.sv
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet;
    logic       final_octet;

    modport source (output valid, output octet, output final_octet, input ready);
    modport sink   (input valid, input octet, input final_octet, output ready);
endinterface

interface spd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last_of_run;

    modport source (output valid, output kind, output value, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input value, input last_of_run,
                    output ready);
endinterface

### design/sms_pdu_deframer.sv
// The first result of an octet is shown in the cycle after its transfer.
// Throughput: one octet per cycle while each octet yields at most one result
// and the port is ready; an octet with more results holds the input until its
// last is taken; the three-entry buffer gives out one result per ready cycle.
// Reset (synchronous, active low) empties the buffer and returns the header
// walk to the SMSC length octet.
module sms_pdu_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spd_in_if.sink     i_in,
    spd_out_if.source  o_out
);

    spd_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_remain, n_remain;
    logic [1:0]       r_mtype, n_mtype;
    logic             r_wide, n_wide;
    logic [6:0]       r_carry, n_carry;
    logic [2:0]       r_ccnt, n_ccnt;
    logic [7:0]       r_hold, n_hold;
    logic             r_held, n_held;
    logic             r_ended, n_ended;

    spd_pkg::t_result r_res [spd_pkg::MAX_RESULTS];
    spd_pkg::t_result v_res [spd_pkg::MAX_RESULTS];
    logic [1:0]       r_cnt;
    logic [1:0]       v_n;

    logic             w_in_ready;
    logic             w_acc;
    logic             w_out_xfer;

    // Take a new octet when the buffer empties this cycle
    assign w_in_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign w_acc      = i_in.valid && w_in_ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = w_in_ready;

    // Drive result port from the buffer head
    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.kind        = r_res[0].kind;
    assign o_out.value       = r_res[0].value;
    assign o_out.last_of_run = r_res[0].last;

    // Decode one octet: next state and its results
    always_comb begin
        logic [7:0] v_b;
        logic [2:0] v_lb;
        logic [6:0] v_mask;
        logic [6:0] v_ch;
        logic [8:0] v_len;
        logic [15:0] v_unit;

        v_b    = i_in.octet;
        v_lb   = (r_ccnt == 3'd7) ? 3'd6 : r_ccnt;
        v_mask = 7'h7F >> v_lb;
        v_ch   = 7'(((v_b[6:0] & v_mask) << v_lb) + r_carry);
        v_len  = ({1'b0, v_b} + 9'd1) >> 1;
        v_unit = {r_hold, v_b};

        n_phase  = r_phase;
        n_remain = r_remain;
        n_mtype  = r_mtype;
        n_wide   = r_wide;
        n_carry  = r_carry;
        n_ccnt   = r_ccnt;
        n_hold   = r_hold;
        n_held   = r_held;
        n_ended  = r_ended;

        v_n = 2'd0;
        for (int k = 0; k < spd_pkg::MAX_RESULTS; k++) begin
            v_res[k] = '{kind: spd_pkg::KIND_END, value: 16'd0, last: 1'b0};
        end

        unique case (r_phase)
            spd_pkg::PH_SMSC_LEN: begin
                if (v_b == 8'd0) begin
                    n_phase = spd_pkg::PH_FIRST;
                end else begin
                    n_remain = v_b - 8'd1;
                    n_phase  = spd_pkg::PH_SMSC_TOA;
                end
            end
            spd_pkg::PH_SMSC_TOA: begin
                n_phase = (r_remain == 8'd0) ? spd_pkg::PH_FIRST : spd_pkg::PH_SMSC_DIG;
            end
            spd_pkg::PH_SMSC_DIG: begin
                v_res[v_n] = '{kind: spd_pkg::KIND_SMSC, value: {12'd0, v_b[3:0]},
                               last: 1'b0};
                v_n = v_n + 2'd1;
                if (v_b[7:4] != spd_pkg::FILLER_NIBBLE) begin
                    v_res[v_n] = '{kind: spd_pkg::KIND_SMSC, value: {12'd0, v_b[7:4]},
                                   last: 1'b0};
                    v_n = v_n + 2'd1;
                end
                n_remain = r_remain - 8'd1;
                if (r_remain == 8'd1) n_phase = spd_pkg::PH_FIRST;
            end
            spd_pkg::PH_FIRST: begin
                n_mtype = v_b[1:0];
                n_phase = (v_b[1:0] == spd_pkg::TYPE_SUBMIT) ? spd_pkg::PH_MR
                                                              : spd_pkg::PH_DA_LEN;
            end
            spd_pkg::PH_MR: begin
                n_phase = spd_pkg::PH_DA_LEN;
            end
            spd_pkg::PH_DA_LEN: begin
                n_remain = v_len[7:0];
                n_phase  = spd_pkg::PH_DA_TOA;
            end
            spd_pkg::PH_DA_TOA: begin
                n_phase = (r_remain == 8'd0) ? spd_pkg::PH_PID : spd_pkg::PH_DA_DIG;
            end
            spd_pkg::PH_DA_DIG: begin
                v_res[v_n] = '{kind: spd_pkg::KIND_DEST, value: {12'd0, v_b[3:0]},
                               last: 1'b0};
                v_n = v_n + 2'd1;
                if (v_b[7:4] != spd_pkg::FILLER_NIBBLE) begin
                    v_res[v_n] = '{kind: spd_pkg::KIND_DEST, value: {12'd0, v_b[7:4]},
                                   last: 1'b0};
                    v_n = v_n + 2'd1;
                end
                n_remain = r_remain - 8'd1;
                if (r_remain == 8'd1) n_phase = spd_pkg::PH_PID;
            end
            spd_pkg::PH_PID: begin
                n_phase = spd_pkg::PH_DCS;
            end
            spd_pkg::PH_DCS: begin
                n_wide = (v_b == spd_pkg::DCS_UCS2);
                if (r_mtype == spd_pkg::TYPE_DELIVER) begin
                    n_remain = spd_pkg::SCTS_OCTETS;
                    n_phase  = spd_pkg::PH_SCTS;
                end else begin
                    n_phase = spd_pkg::PH_UDL;
                end
            end
            spd_pkg::PH_SCTS: begin
                n_remain = r_remain - 8'd1;
                if (r_remain == 8'd1) n_phase = spd_pkg::PH_UDL;
            end
            spd_pkg::PH_UDL: begin
                n_phase = spd_pkg::PH_UD;
            end
            spd_pkg::PH_UD: begin
                if (r_wide) begin
                    // Pair octets into big-endian UCS-2 units
                    if (r_ended) begin
                        n_ended = 1'b1;
                    end else if (!r_held) begin
                        n_hold = v_b;
                        n_held = 1'b1;
                    end else begin
                        n_held = 1'b0;
                        if (v_unit == 16'd0) begin
                            n_ended = 1'b1;
                        end else begin
                            v_res[v_n] = '{kind: spd_pkg::KIND_TEXT, value: v_unit,
                                           last: 1'b0};
                            v_n = v_n + 2'd1;
                        end
                    end
                end else begin
                    // Unpack septets; every seventh octet releases an extra one
                    v_res[v_n] = '{kind: spd_pkg::KIND_TEXT, value: {9'd0, v_ch},
                                   last: 1'b0};
                    v_n = v_n + 2'd1;
                    n_carry = 7'(v_b >> (3'd7 - v_lb));
                    if (v_lb == 3'd6) begin
                        v_res[v_n] = '{kind: spd_pkg::KIND_TEXT, value: {9'd0, v_b[7:1]},
                                       last: 1'b0};
                        v_n = v_n + 2'd1;
                        n_carry = 7'd0;
                        n_ccnt  = 3'd0;
                    end else begin
                        n_ccnt = v_lb + 3'd1;
                    end
                end
            end
            default: begin
                n_phase = spd_pkg::PH_SMSC_LEN;
            end
        endcase

        // Close the PDU: end marker, then back to the start
        if (i_in.final_octet) begin
            v_res[v_n] = '{kind: spd_pkg::KIND_END, value: 16'd0, last: 1'b0};
            v_n = v_n + 2'd1;
            n_phase  = spd_pkg::PH_SMSC_LEN;
            n_remain = 8'd0;
            n_mtype  = 2'd0;
            n_wide   = 1'b0;
            n_carry  = 7'd0;
            n_ccnt   = 3'd0;
            n_hold   = 8'd0;
            n_held   = 1'b0;
            n_ended  = 1'b0;
        end

        // Flag the last result of this octet
        if (v_n != 2'd0) v_res[v_n - 2'd1].last = 1'b1;
    end

    // Advance decode state and buffer fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= spd_pkg::PH_SMSC_LEN;
            r_remain <= 8'd0;
            r_mtype  <= 2'd0;
            r_wide   <= 1'b0;
            r_carry  <= 7'd0;
            r_ccnt   <= 3'd0;
            r_hold   <= 8'd0;
            r_held   <= 1'b0;
            r_ended  <= 1'b0;
            r_cnt    <= 2'd0;
        end else if (w_acc) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_mtype  <= n_mtype;
            r_wide   <= n_wide;
            r_carry  <= n_carry;
            r_ccnt   <= n_ccnt;
            r_hold   <= n_hold;
            r_held   <= n_held;
            r_ended  <= n_ended;
            r_cnt    <= v_n;
        end else if (w_out_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Load results on a transfer in, shift toward the head on a transfer out
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= v_res;
        end else if (w_out_xfer) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

### design/spd_checker.sv
module spd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [15:0] i_out_value,
    input logic        i_out_last
);

    // Buffer is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_value)
            && $stable(i_out_last))
        else $error("stalled result changed");

    // End marker carries zero and closes the run
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == spd_pkg::KIND_END) |->
            (i_out_value == 16'd0) && i_out_last)
        else $error("malformed end marker");

    // Address digits are single nibbles
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_kind == spd_pkg::KIND_SMSC)
            || (i_out_kind == spd_pkg::KIND_DEST)) |-> (i_out_value[15:4] == 12'd0))
        else $error("digit wider than a nibble");

endmodule

bind sms_pdu_deframer spd_checker u_spd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last_of_run)
);
